/* rtl/color_rect_count_fenwick_2d_unit_assert.svh */
// Assertion macros for the per-color rectangle counter.
`ifndef COLOR_RECT_COUNT_FENWICK_2D_UNIT_ASSERT_SVH
`define COLOR_RECT_COUNT_FENWICK_2D_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CRCF2D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CRCF2D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/crcf2d_pkg.sv */
// Shared constants, register codes and controller interface types.
`default_nettype none

package crcf2d_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int NUM_COLORS_DEF = 16;

	localparam int COORD_W = 6;
	localparam int COLOR_W = 4;
	localparam int COUNT_W = 13;
	localparam int CFG_W   = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] ROWS_USED_RST = 7'd64;
	localparam logic [CFG_W-1:0] COLS_USED_RST = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'd1;

	localparam logic REQ_SET   = 1'b0;
	localparam logic REQ_COUNT = 1'b1;

	typedef struct packed {
		logic clr_step;
		logic load_req;
		logic cell_rd;
		logic cell_wr;
		logic upd_sub_init;
		logic upd_add_init;
		logic upd_step;
		logic tree_rd;
		logic tree_wr;
		logic pfx_init;
		logic pfx_next;
		logic pfx_step;
		logic acc_en;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bad;
		logic is_count;
		logic cell_valid;
		logic upd_neg;
		logic upd_last;
		logic pfx_empty;
		logic pfx_last;
		logic pass_last;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/crcf2d_datapath.sv */
// Datapath: config registers, cell and tree memories, Fenwick index walkers, accumulator.
`default_nettype none

module crcf2d_datapath
	import crcf2d_pkg::*;
#(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int NUM_COLORS = NUM_COLORS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_type,
	input  wire logic [COORD_W-1:0]   row_lo,
	input  wire logic [COORD_W-1:0]   row_hi,
	input  wire logic [COORD_W-1:0]   col_lo,
	input  wire logic [COORD_W-1:0]   col_hi,
	input  wire logic [COLOR_W-1:0]   color,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	output logic [COUNT_W-1:0]        cell_count,
	output logic                      bad_request
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int KW = $clog2(NUM_COLORS);
	localparam int IW = $clog2(MAX_ROWS + 1);
	localparam int JW = $clog2(MAX_COLS + 1);
	localparam int CELL_AW = RW + CW;
	localparam int TREE_AW = KW + RW + CW;
	localparam int CELL_DEPTH = 2 ** CELL_AW;
	localparam int TREE_DEPTH = 2 ** TREE_AW;

	logic [CFG_W-1:0]   rows_q, cols_q;
	logic               type_q;
	logic [COORD_W-1:0] rl_q, rh_q, cl_q, ch_q;
	logic [COLOR_W-1:0] color_q;

	logic [KW:0]          cell_mem [CELL_DEPTH];
	logic [COUNT_W-1:0]   tree_mem [TREE_DEPTH];
	logic [KW:0]          cell_rd_q;
	logic [COUNT_W-1:0]   tree_rd_q;

	logic [TREE_AW-1:0] clr_q;
	logic [IW-1:0]      i_q;
	logic [JW-1:0]      j_q, j_start_q;
	logic [KW-1:0]      k_q;
	logic               upd_neg_q;
	logic               pfx_neg_q;
	logic [1:0]         pass_q;
	logic [COUNT_W-1:0] acc_q;
	logic [COUNT_W-1:0] cnt_out_q;
	logic               bad_out_q;

	// Request check.
	logic rl_ok, rh_ok, cl_ok, ch_ok, color_ok, bad;

	always_comb begin
		rl_ok    = ({1'b0, rl_q} < rows_q) && (int'(rl_q) < MAX_ROWS);
		rh_ok    = ({1'b0, rh_q} < rows_q) && (int'(rh_q) < MAX_ROWS);
		cl_ok    = ({1'b0, cl_q} < cols_q) && (int'(cl_q) < MAX_COLS);
		ch_ok    = ({1'b0, ch_q} < cols_q) && (int'(ch_q) < MAX_COLS);
		color_ok = int'(color_q) < NUM_COLORS;
		bad = !color_ok || !rl_ok || !cl_ok;
		if (type_q == REQ_COUNT) begin
			if (!rh_ok || !ch_ok || (rl_q > rh_q) || (cl_q > ch_q))
				bad = 1'b1;
		end
	end

	// Fenwick index arithmetic.
	logic [IW-1:0] i_low, i_dn;
	logic [JW-1:0] j_low, j_dn;
	logic [IW:0]   i_up;
	logic [JW:0]   j_up;
	logic          i_up_done, j_up_done;

	always_comb begin
		i_low = i_q & (~i_q + IW'(1));
		j_low = j_q & (~j_q + JW'(1));
		i_up  = {1'b0, i_q} + {1'b0, i_low};
		j_up  = {1'b0, j_q} + {1'b0, j_low};
		i_dn  = i_q - i_low;
		j_dn  = j_q - j_low;
		i_up_done = i_up > (IW + 1)'(MAX_ROWS);
		j_up_done = j_up > (JW + 1)'(MAX_COLS);
	end

	// Start points of the four prefix sums; odd passes end at row_lo, upper passes at col_lo.
	logic [1:0]          pass_sel;
	logic [IW-1:0]       pfx_i0, upd_i0;
	logic [JW-1:0]       pfx_j0, upd_j0;

	always_comb begin
		pass_sel = cmd.pfx_init ? 2'd0 : pass_q + 2'd1;
		pfx_i0 = pass_sel[0] ? IW'({1'b0, rl_q}) : IW'({1'b0, rh_q} + 7'd1);
		pfx_j0 = pass_sel[1] ? JW'({1'b0, cl_q}) : JW'({1'b0, ch_q} + 7'd1);
		upd_i0 = IW'({1'b0, rl_q} + 7'd1);
		upd_j0 = JW'({1'b0, cl_q} + 7'd1);
	end

	logic [TREE_AW-1:0] tree_addr, tree_waddr;
	logic [CELL_AW-1:0] cell_addr, cell_waddr;
	logic [COUNT_W-1:0] tree_wdata;
	logic [KW:0]        cell_wdata;
	logic               tree_we, cell_we;

	always_comb begin
		tree_addr = {k_q, RW'(i_q - IW'(1)), CW'(j_q - JW'(1))};
		cell_addr = {RW'(rl_q), CW'(cl_q)};
		tree_we   = cmd.clr_step | cmd.tree_wr;
		cell_we   = cmd.clr_step | cmd.cell_wr;
		tree_waddr = cmd.clr_step ? clr_q : tree_addr;
		cell_waddr = cmd.clr_step ? clr_q[CELL_AW-1:0] : cell_addr;
		tree_wdata = cmd.clr_step ? '0
			: tree_rd_q + (upd_neg_q ? {COUNT_W{1'b1}} : COUNT_W'(1));
		cell_wdata = cmd.clr_step ? '0 : {1'b1, KW'(color_q)};
	end

	always_ff @(posedge clk) begin
		if (tree_we)
			tree_mem[tree_waddr] <= tree_wdata;
		if (cmd.tree_rd)
			tree_rd_q <= tree_mem[tree_addr];
	end

	always_ff @(posedge clk) begin
		if (cell_we)
			cell_mem[cell_waddr] <= cell_wdata;
		if (cmd.cell_rd)
			cell_rd_q <= cell_mem[cell_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_USED_RST;
			cols_q <= COLS_USED_RST;
			clr_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_USED: rows_q <= cfg_data;
					REG_COLS_USED: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_step)
				clr_q <= clr_q + TREE_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q  <= req_type;
			rl_q    <= row_lo;
			rh_q    <= row_hi;
			cl_q    <= col_lo;
			ch_q    <= col_hi;
			color_q <= color;
			acc_q   <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= pfx_neg_q ? acc_q - tree_rd_q : acc_q + tree_rd_q;
		end

		if (cmd.upd_sub_init || cmd.upd_add_init) begin
			i_q       <= upd_i0;
			j_q       <= upd_j0;
			j_start_q <= upd_j0;
			upd_neg_q <= cmd.upd_sub_init;
			k_q       <= cmd.upd_sub_init ? cell_rd_q[KW-1:0] : KW'(color_q);
		end else if (cmd.pfx_init || cmd.pfx_next) begin
			i_q       <= pfx_i0;
			j_q       <= pfx_j0;
			j_start_q <= pfx_j0;
			pass_q    <= pass_sel;
			pfx_neg_q <= pass_sel[0] ^ pass_sel[1];
			k_q       <= KW'(color_q);
		end else if (cmd.upd_step) begin
			if (j_up_done) begin
				j_q <= j_start_q;
				i_q <= i_up[IW-1:0];
			end else begin
				j_q <= j_up[JW-1:0];
			end
		end else if (cmd.pfx_step) begin
			if (j_dn == '0) begin
				j_q <= j_start_q;
				i_q <= i_dn;
			end else begin
				j_q <= j_dn;
			end
		end

		if (cmd.out_load) begin
			cnt_out_q <= acc_q;
			bad_out_q <= bad;
		end
	end

	always_comb begin
		sts.clr_done   = &clr_q;
		sts.bad        = bad;
		sts.is_count   = type_q == REQ_COUNT;
		sts.cell_valid = cell_rd_q[KW];
		sts.upd_neg    = upd_neg_q;
		sts.upd_last   = i_up_done && j_up_done;
		sts.pfx_empty  = (i_q == '0) || (j_q == '0);
		sts.pfx_last   = (i_dn == '0) && (j_dn == '0);
		sts.pass_last  = pass_q == 2'd3;
	end

	assign cell_count  = cnt_out_q;
	assign bad_request = bad_out_q;

endmodule

`default_nettype wire

/* rtl/crcf2d_ctrl.sv */
// Controller: sequences clearing, cell lookup, tree updates and prefix sums.
`default_nettype none

module crcf2d_ctrl
	import crcf2d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CHECK   = 4'd2;
	localparam logic [3:0] S_CELL    = 4'd3;
	localparam logic [3:0] S_UPD_RD  = 4'd4;
	localparam logic [3:0] S_UPD_WR  = 4'd5;
	localparam logic [3:0] S_PFX_CHK = 4'd6;
	localparam logic [3:0] S_PFX_RD  = 4'd7;
	localparam logic [3:0] S_PFX_ACC = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.bad) begin
					state_d = S_DONE;
				end else if (sts.is_count) begin
					cmd.pfx_init = 1'b1;
					state_d = S_PFX_CHK;
				end else begin
					cmd.cell_rd = 1'b1;
					state_d = S_CELL;
				end
			end
			S_CELL: begin
				cmd.cell_wr = 1'b1;
				if (sts.cell_valid)
					cmd.upd_sub_init = 1'b1;
				else
					cmd.upd_add_init = 1'b1;
				state_d = S_UPD_RD;
			end
			S_UPD_RD: begin
				cmd.tree_rd = 1'b1;
				state_d = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.tree_wr = 1'b1;
				if (!sts.upd_last) begin
					cmd.upd_step = 1'b1;
					state_d = S_UPD_RD;
				end else if (sts.upd_neg) begin
					// The old color is removed; now add the new one.
					cmd.upd_add_init = 1'b1;
					state_d = S_UPD_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PFX_CHK: begin
				if (!sts.pfx_empty) begin
					state_d = S_PFX_RD;
				end else if (sts.pass_last) begin
					state_d = S_DONE;
				end else begin
					cmd.pfx_next = 1'b1;
				end
			end
			S_PFX_RD: begin
				cmd.tree_rd = 1'b1;
				state_d = S_PFX_ACC;
			end
			S_PFX_ACC: begin
				cmd.acc_en = 1'b1;
				if (!sts.pfx_last) begin
					cmd.pfx_step = 1'b1;
					state_d = S_PFX_RD;
				end else if (sts.pass_last) begin
					state_d = S_DONE;
				end else begin
					cmd.pfx_next = 1'b1;
					state_d = S_PFX_CHK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/color_rect_count_fenwick_2d_unit.sv */
// Top level of the per-color rectangle cell counter over 2-D Fenwick trees.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    one set or count request
//  m_axis    out        m_axis_tvalid/m_axis_tready    count and reject flag
//  cfg       in         cfg_we                         rows_used, cols_used
//
// After reset a clearing pass writes every tree counter and cell entry, one
// address a cycle, over NUM_COLORS * 2^clog2(MAX_ROWS) * 2^clog2(MAX_COLS) tree
// addresses (65536 with the defaults); no request is taken meanwhile.
// Each tree counter access is a read state followed by a write or accumulate state.
// A set reads the cell, then walks the tree for the old color (subtracting) if the
// cell held one, and for the new color (adding); a count sums four prefix walks.
// A rejected request goes from S_CHECK straight to S_DONE. The result register
// lets the next request start while a result waits on m_axis_tready.
`default_nettype none

module color_rect_count_fenwick_2d_unit
	import crcf2d_pkg::*;
#(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int NUM_COLORS = NUM_COLORS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// row_lo[5:0], row_hi[11:6], col_lo[17:12], col_hi[23:18], color[27:24], zero
	input  wire logic [31:0]          s_axis_tdata,
	// req_type[0]
	input  wire logic                 s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// cell_count[12:0], zero
	output logic [15:0]               m_axis_tdata,
	// bad_request[0]
	output logic                      m_axis_tuser
);

	`include "color_rect_count_fenwick_2d_unit_assert.svh"

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [COUNT_W-1:0] cell_count;

	crcf2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	crcf2d_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.NUM_COLORS (NUM_COLORS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (s_axis_tuser),
		.row_lo      (s_axis_tdata[5:0]),
		.row_hi      (s_axis_tdata[11:6]),
		.col_lo      (s_axis_tdata[17:12]),
		.col_hi      (s_axis_tdata[23:18]),
		.color       (s_axis_tdata[27:24]),
		.cmd         (cmd),
		.sts         (sts),
		.cell_count  (cell_count),
		.bad_request (m_axis_tuser)
	);

	assign m_axis_tdata = {3'b000, cell_count};

	// Only one request is in work at a time.
	`CRCF2D_ASSERT_NXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
	// A new result appears only after the request side was busy.
	`CRCF2D_ASSERT_IMP(a_result_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without work")
	// A rejected request never reports a count.
	`CRCF2D_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "nonzero count on reject")

endmodule

`default_nettype wire
